// ===== rtl/psv_pkg.sv =====
// ----------------------------------------------------------------------------
// psv_pkg
// shared types and widths for the plucked string voice and its divider
// ----------------------------------------------------------------------------
`default_nettype none

package psv_pkg;

  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_QUO_W = 16;

  // configuration register indexes
  localparam logic [2:0] CFG_DELAY_LENGTH = 3'd0;
  localparam logic [2:0] CFG_FILTER_ALPHA = 3'd1;
  localparam logic [2:0] CFG_FB_GAIN      = 3'd2;
  localparam logic [2:0] CFG_BODY_MIX     = 3'd3;
  localparam logic [2:0] CFG_PHASE_STEP   = 3'd4;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/psv_div.sv =====
// ----------------------------------------------------------------------------
// psv_div
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
`default_nettype none

module psv_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire psv_pkg::div_req_t req,
  output psv_pkg::div_rsp_t     rsp
);

  localparam int NW = psv_pkg::DIV_NUM_W;
  localparam int QW = psv_pkg::DIV_QUO_W;
  localparam int CW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dsh_r, dsh_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic          ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW - 1);
      rem_nxt  = req.num;
      dsh_nxt  = NW'(req.den) << (QW - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[QW-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/plucked_string_voice_core.sv =====
// ----------------------------------------------------------------------------
// plucked_string_voice_core
// plucked string voice: delay line, interpolation, lowpass, loop gain, burst
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one sample tick: in_strike and
//   in_strike_level. each transfer yields exactly one out_audio_out transfer
//   on the output channel (out_valid/out_ready).
//   configuration: cfg_we with cfg_index 0..4 writes delay_length,
//   filter_alpha, feedback gain, body_mix, phase_step; the user must write
//   them only while idle, as the core itself does not enforce this.
//   timing: one shared 33x26 multiplier and a one-bit-per-cycle divider run
//   under a sequencer. a feedback sample reads the line twice on the single
//   read port, then interpolates, lowpasses, applies the gain and writes.
//   a burst sample runs lcg, sine division, mix, level scale, lowpass, write.
//   in_ready is high only while the sequencer is idle.
//   reset: a clearing pass writes zero to all LINE_DEPTH line entries, one
//   per cycle, so in_ready stays low until the clearing pass is done.
//   stall: a finished sample sits in the output register; the next input is
//   taken meanwhile and the sequencer waits before its write only if the
//   output register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module plucked_string_voice_core #(
  parameter int LINE_DEPTH          = 2048,
  parameter int DELAY_FRACTION_BITS = 8,
  parameter int SINE_TABLE_DEPTH    = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_strike,
  input  wire logic [14:0]        in_strike_level,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_audio_out,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [18:0]        cfg_data
);

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int FB  = DELAY_FRACTION_BITS;
  localparam int FW  = FB + 1;
  localparam int DW  = (AW + FB + 2 > 19) ? AW + FB + 2 : 19;
  localparam int PW  = 59;
  localparam int SINE_SHIFT = 16 - $clog2(SINE_TABLE_DEPTH);

  localparam logic [DW-1:0] SPAN  = DW'(LINE_DEPTH) << FB;
  localparam logic [DW-1:0] DMIN  = DW'(2) << FB;
  localparam logic [DW-1:0] DMAX  = DW'(LINE_DEPTH - 2) << FB;
  localparam logic [DW-1:0] FMASK = (DW'(1) << FB) - DW'(1);
  localparam logic [AW-1:0] LAST  = AW'(LINE_DEPTH - 1);
  localparam logic [15:0]   PQ_MASK = 16'hFFFF << SINE_SHIFT;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [32:0] SINE_DEN_BASE = 33'd5368709120;
  localparam logic signed [PW-1:0] EXC_LIM = PW'(32767 * 256);
  localparam logic signed [PW-1:0] S24_MAX = PW'(8388607);
  localparam logic signed [PW-1:0] S24_MIN = -PW'(8388608);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_RD0       = 5'd2;
  localparam logic [4:0] S_RD1       = 5'd3;
  localparam logic [4:0] S_INT_MUL   = 5'd4;
  localparam logic [4:0] S_INT_ADD   = 5'd5;
  localparam logic [4:0] S_LCG_MUL   = 5'd6;
  localparam logic [4:0] S_LCG_ADD   = 5'd7;
  localparam logic [4:0] S_SQ_MUL    = 5'd10;
  localparam logic [4:0] S_SIN_START = 5'd11;
  localparam logic [4:0] S_SIN_WAIT  = 5'd12;
  localparam logic [4:0] S_MIX0      = 5'd13;
  localparam logic [4:0] S_MIX1      = 5'd14;
  localparam logic [4:0] S_MIX2      = 5'd15;
  localparam logic [4:0] S_EXC_MUL   = 5'd16;
  localparam logic [4:0] S_EXC       = 5'd17;
  localparam logic [4:0] S_LP_MUL    = 5'd18;
  localparam logic [4:0] S_LP_ADD    = 5'd19;
  localparam logic [4:0] S_FB_MUL    = 5'd20;
  localparam logic [4:0] S_FB_ADD    = 5'd21;
  localparam logic [4:0] S_WRITE     = 5'd22;

  function automatic logic signed [23:0] sat24(input logic signed [PW-1:0] v);
    logic signed [23:0] res;
    if (v > S24_MAX) begin
      res = 24'sh7FFFFF;
    end else if (v < S24_MIN) begin
      res = 24'sh800000;
    end else begin
      res = 24'(v);
    end
    return res;
  endfunction

  // configuration
  logic [18:0] delay_length_r, delay_length_nxt;
  logic [16:0] filter_alpha_r, filter_alpha_nxt;
  logic [15:0] fb_gain_r, fb_gain_nxt;
  logic [16:0] body_mix_r, body_mix_nxt;
  logic [15:0] phase_step_r, phase_step_nxt;

  // sequencer and voice state
  logic [4:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic signed [23:0] filt_r, filt_nxt;
  logic [31:0]        seed_r, seed_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [15:0]        phase_r, phase_nxt;
  logic [14:0]        amp_r, amp_nxt;
  logic               exc_r, exc_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working registers
  logic [AW-1:0]      r1_r, r1_nxt;
  logic [FW-1:0]      frac_r, frac_nxt;
  logic signed [23:0] s0_r, s0_nxt;
  logic signed [23:0] x_r, x_nxt;
  logic signed [23:0] fresh_r, fresh_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic [15:0]        pq_r, pq_nxt;
  logic signed [16:0] sn_r, sn_nxt;
  logic signed [16:0] mix_r, mix_nxt;
  logic signed [15:0] out_data_r, out_data_nxt;

  // shared multiplier
  logic signed [32:0]   mul_a;
  logic signed [25:0]   mul_b;
  logic signed [PW-1:0] p_r;

  // delay line
  logic signed [23:0] mem [LINE_DEPTH];
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [23:0] mem_wdata;
  logic signed [23:0] rd_data_r;

  psv_pkg::div_req_t div_req;
  psv_pkg::div_rsp_t div_rsp;

  logic [16:0]        alpha_c, body_c;
  logic [DW-1:0]      d_raw, d_cl, pos_sum, pos;
  logic [AW-1:0]      r0_w, r1_w, burst_n;
  logic [FW-1:0]      frac_w;
  logic [14:0]        sin_mag;
  logic signed [PW-1:0] mix_sum, e_full, e_cl;

  assign alpha_c = (filter_alpha_r > Q16_ONE) ? Q16_ONE : filter_alpha_r;
  assign body_c  = (body_mix_r > Q16_ONE) ? Q16_ONE : body_mix_r;

  assign d_raw   = DW'(delay_length_r);
  assign d_cl    = (d_raw < DMIN) ? DMIN : ((d_raw > DMAX) ? DMAX : d_raw);
  assign burst_n = AW'(d_cl >> FB);
  assign pos_sum = (DW'(wp_r) << FB) + SPAN - d_cl;
  assign pos     = (pos_sum >= SPAN) ? pos_sum - SPAN : pos_sum;
  assign r0_w    = AW'(pos >> FB);
  assign r1_w    = (r0_w == LAST) ? '0 : r0_w + 1'b1;
  assign frac_w  = FW'(pos & FMASK);

  assign sin_mag = (div_rsp.quo > 16'd32767) ? 15'd32767 : div_rsp.quo[14:0];
  assign mix_sum = (PW'(acc_r) + p_r) >>> 16;
  assign e_full  = p_r >>> 7;
  assign e_cl    = (e_full > EXC_LIM) ? EXC_LIM : ((e_full < -EXC_LIM) ? -EXC_LIM : e_full);

  psv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    delay_length_nxt = delay_length_r;
    filter_alpha_nxt = filter_alpha_r;
    fb_gain_nxt      = fb_gain_r;
    body_mix_nxt     = body_mix_r;
    phase_step_nxt   = phase_step_r;
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    wp_nxt           = wp_r;
    filt_nxt         = filt_r;
    seed_nxt         = seed_r;
    cnt_nxt          = cnt_r;
    phase_nxt        = phase_r;
    amp_nxt          = amp_r;
    exc_nxt          = exc_r;
    out_valid_nxt    = out_valid_r;
    r1_nxt           = r1_r;
    frac_nxt         = frac_r;
    s0_nxt           = s0_r;
    x_nxt            = x_r;
    fresh_nxt        = fresh_r;
    acc_nxt          = acc_r;
    pq_nxt           = pq_r;
    sn_nxt           = sn_r;
    mix_nxt          = mix_r;
    out_data_nxt     = out_data_r;
    mul_a            = '0;
    mul_b            = '0;
    mem_we           = 1'b0;
    mem_waddr        = wp_r;
    mem_wdata        = fresh_r;
    mem_re           = 1'b0;
    mem_raddr        = r0_w;
    div_req          = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        psv_pkg::CFG_DELAY_LENGTH: delay_length_nxt = cfg_data;
        psv_pkg::CFG_FILTER_ALPHA: filter_alpha_nxt = cfg_data[16:0];
        psv_pkg::CFG_FB_GAIN:      fb_gain_nxt      = cfg_data[15:0];
        psv_pkg::CFG_BODY_MIX:     body_mix_nxt     = cfg_data[16:0];
        psv_pkg::CFG_PHASE_STEP:   phase_step_nxt   = cfg_data[15:0];
        default: ;
      endcase
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          exc_nxt = in_strike | (cnt_r != '0);
          if (in_strike) begin
            cnt_nxt   = burst_n;
            phase_nxt = '0;
            amp_nxt   = in_strike_level;
            filt_nxt  = '0;
          end
          state_nxt = (in_strike | (cnt_r != '0)) ? S_LCG_MUL : S_RD0;
        end
      end
      S_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = r0_w;
        r1_nxt    = r1_w;
        frac_nxt  = frac_w;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = r1_r;
        s0_nxt    = rd_data_r;
        state_nxt = S_INT_MUL;
      end
      S_INT_MUL: begin
        mul_a     = 33'(25'(rd_data_r) - 25'(s0_r));
        mul_b     = 26'(frac_r);
        state_nxt = S_INT_ADD;
      end
      S_INT_ADD: begin
        x_nxt     = 24'(PW'(s0_r) + (p_r >>> FB));
        state_nxt = S_LP_MUL;
      end
      S_LCG_MUL: begin
        mul_a     = 33'({1'b0, seed_r});
        mul_b     = 26'(LCG_MUL);
        state_nxt = S_LCG_ADD;
      end
      S_LCG_ADD: begin
        seed_nxt  = p_r[31:0] + LCG_INC;
        // phase quantized down to the sine table steps
        pq_nxt    = phase_r & PQ_MASK;
        state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        mul_a     = 33'(pq_r[14:0]);
        mul_b     = 26'(17'd32768 - {2'b00, pq_r[14:0]});
        state_nxt = S_SIN_START;
      end
      S_SIN_START: begin
        // half wave: 16 p << 15 over 5 * 2^30 - 4 p
        div_req.start = 1'b1;
        div_req.num   = psv_pkg::DIV_NUM_W'(p_r) << 19;
        div_req.den   = SINE_DEN_BASE - (psv_pkg::DIV_DEN_W'(p_r) << 2);
        state_nxt     = S_SIN_WAIT;
      end
      S_SIN_WAIT: begin
        if (div_rsp.done) begin
          sn_nxt    = pq_r[15] ? -17'(sin_mag) : 17'(sin_mag);
          state_nxt = S_MIX0;
        end
      end
      S_MIX0: begin
        mul_a     = 33'($signed(seed_r[31:16]));
        mul_b     = 26'(Q16_ONE - body_c);
        state_nxt = S_MIX1;
      end
      S_MIX1: begin
        acc_nxt   = 34'(p_r);
        mul_a     = 33'(sn_r);
        mul_b     = 26'(body_c);
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        mix_nxt   = 17'(mix_sum);
        state_nxt = S_EXC_MUL;
      end
      S_EXC_MUL: begin
        mul_a     = 33'(mix_r);
        mul_b     = 26'(amp_r);
        state_nxt = S_EXC;
      end
      S_EXC: begin
        x_nxt     = 24'(e_cl);
        fresh_nxt = 24'(e_cl);
        phase_nxt = phase_r + phase_step_r;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_LP_MUL;
      end
      S_LP_MUL: begin
        mul_a     = 33'(25'(x_r) - 25'(filt_r));
        mul_b     = 26'(alpha_c);
        state_nxt = S_LP_ADD;
      end
      S_LP_ADD: begin
        filt_nxt  = sat24(PW'(filt_r) + (p_r >>> 16));
        state_nxt = exc_r ? S_WRITE : S_FB_MUL;
      end
      S_FB_MUL: begin
        mul_a     = 33'(filt_r);
        mul_b     = 26'(fb_gain_r);
        state_nxt = S_FB_ADD;
      end
      S_FB_ADD: begin
        fresh_nxt = 24'(p_r >>> 16);
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_r || out_ready) begin
          mem_we        = 1'b1;
          mem_waddr     = wp_r;
          mem_wdata     = fresh_r;
          wp_nxt        = (wp_r == LAST) ? '0 : wp_r + 1'b1;
          out_valid_nxt = 1'b1;
          // truncate toward zero
          out_data_nxt  = fresh_r[23:8] + {15'd0, fresh_r[23] & (|fresh_r[7:0])};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_length_r <= 19'd25600;
      filter_alpha_r <= 17'd32768;
      fb_gain_r      <= 16'd65000;
      body_mix_r     <= 17'd0;
      phase_step_r   <= 16'd655;
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      wp_r           <= '0;
      filt_r         <= '0;
      seed_r         <= 32'd1;
      cnt_r          <= '0;
      phase_r        <= '0;
      amp_r          <= '0;
      exc_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      delay_length_r <= delay_length_nxt;
      filter_alpha_r <= filter_alpha_nxt;
      fb_gain_r      <= fb_gain_nxt;
      body_mix_r     <= body_mix_nxt;
      phase_step_r   <= phase_step_nxt;
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      wp_r           <= wp_nxt;
      filt_r         <= filt_nxt;
      seed_r         <= seed_nxt;
      cnt_r          <= cnt_nxt;
      phase_r        <= phase_nxt;
      amp_r          <= amp_nxt;
      exc_r          <= exc_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    r1_r       <= r1_nxt;
    frac_r     <= frac_nxt;
    s0_r       <= s0_nxt;
    x_r        <= x_nxt;
    fresh_r    <= fresh_nxt;
    acc_r      <= acc_nxt;
    pq_r       <= pq_nxt;
    sn_r       <= sn_nxt;
    mix_r      <= mix_nxt;
    out_data_r <= out_data_nxt;
    p_r        <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_audio_out = out_data_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_SIN_WAIT))
    else $error("divider finished outside a wait state");

  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WRITE))
    else $error("output loaded outside the write step");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= AW'(LINE_DEPTH - 2))
    else $error("burst count beyond line length");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready && !out_valid_r)
    else $error("transfer during clearing pass");

endmodule

`default_nettype wire

// ===== tb/tb_plucked_string_voice_core.sv =====
// ----------------------------------------------------------------------------
// tb_plucked_string_voice_core
// self-checking bench for the plucked string voice. a local string model
// (delay line, lcg noise, sine burst, lowpass, loop gain) predicts each
// output sample whose value the table does not give. a short directed table
// covers silence after reset, zero and full strike levels, restrikes during
// a burst and out-of-range register values. phases with new register settings,
// random strikes and idling on both sides and one long output hold-off follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_plucked_string_voice_core;

  typedef enum logic [2:0] {
    REG_DELAY = psv_pkg::CFG_DELAY_LENGTH,
    REG_ALPHA = psv_pkg::CFG_FILTER_ALPHA,
    REG_GAIN  = psv_pkg::CFG_FB_GAIN,
    REG_BODY  = psv_pkg::CFG_BODY_MIX,
    REG_STEP  = psv_pkg::CFG_PHASE_STEP
  } reg_index_e;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    reg_index_e         sel;
    logic [18:0]        value;
    logic               strike;
    logic               known;
    logic signed [15:0] audio;
  } plan_row_t;

  localparam int     PLAN_ROWS  = 23;
  localparam int     PHASES     = 6;
  localparam int     PHASE_TICKS = 92;
  localparam int     HOLD_CYCLES = 400;
  localparam longint SPAN       = 64'sd524288;
  localparam longint DELAY_MIN  = 64'sd512;
  localparam longint DELAY_MAX  = 64'sd523776;
  localparam longint EXC_LIMIT  = 64'sd8388352;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_strike = 1'b0;
  logic [14:0] in_strike_level = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_audio_out;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [18:0] cfg_data = '0;

  // string model state
  logic signed [23:0] line_mem [0:2047];
  logic [10:0]        wr_ptr;
  logic signed [23:0] filt_q;
  logic [31:0]        lcg_q;
  logic [11:0]        burst_left;
  logic [15:0]        burst_phase;
  logic [14:0]        burst_amp;
  logic [18:0]        set_delay;
  logic [16:0]        set_alpha;
  logic [15:0]        set_gain;
  logic [16:0]        set_body;
  logic [15:0]        set_step;

  logic signed [15:0] expected_audio [$];
  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  int mismatch_count = 0;
  int n_ticks = 0;
  int n_strikes = 0;
  int n_burst = 0;
  int n_feedback = 0;
  int n_regs = 0;
  int n_checked = 0;

  plucked_string_voice_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_strike       (in_strike),
    .in_strike_level (in_strike_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_audio_out   (out_audio_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 20)
      $display("mismatch %0d: %s got %0d want %0d at %0t", mismatch_count, what, got,
               want, $realtime);
  endtask

  function automatic longint clamp24(input longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  // half-wave rational sine approximation on a phase quantized to 256 steps
  function automatic longint burst_sine(input logic [15:0] ph);
    longint pq, h, p, den, s;
    pq = longint'(ph >> 8) << 8;
    h = pq & 64'sd32767;
    p = h * (64'sd32768 - h);
    den = (longint'(5) << 30) - 4 * p;
    s = ((16 * p) << 15) / den;
    if (s > 64'sd32767) s = 64'sd32767;
    return pq[15] ? -s : s;
  endfunction

  function automatic logic signed [15:0] next_string_sample(input logic strike,
                                                            input logic [14:0] level);
    longint d, alpha, body, gain, amp, pos, frac, s0, s1, raw;
    longint nz, sn, mix, e, f, y, fresh, res, n;
    int r0, r1;
    d = longint'(set_delay);
    alpha = longint'(set_alpha);
    body = longint'(set_body);
    gain = longint'(set_gain);
    if (d < DELAY_MIN) d = DELAY_MIN;
    if (d > DELAY_MAX) d = DELAY_MAX;
    if (alpha > 64'sd65536) alpha = 64'sd65536;
    if (body > 64'sd65536) body = 64'sd65536;
    if (strike) begin
      n = d >> 8;
      if (n < 2) n = 2;
      if (n > 2047) n = 2047;
      burst_left = n[11:0];
      burst_phase = '0;
      burst_amp = level;
      filt_q = '0;
    end
    pos = ((longint'(wr_ptr) << 8) + SPAN - d) % SPAN;
    frac = pos & 64'sd255;
    r0 = int'((pos >> 8) % 2048);
    r1 = (r0 + 1) % 2048;
    s0 = longint'(line_mem[r0]);
    s1 = longint'(line_mem[r1]);
    raw = s0 + (((s1 - s0) * frac) >>> 8);
    f = longint'(filt_q);
    if (burst_left != 0) begin
      lcg_q = lcg_q * 32'd1664525 + 32'd1013904223;
      nz = longint'($signed(lcg_q)) >>> 16;
      sn = burst_sine(burst_phase);
      amp = longint'(burst_amp);
      mix = ((64'sd65536 - body) * nz + body * sn) >>> 16;
      e = (mix * amp) >>> 7;
      if (e > EXC_LIMIT) e = EXC_LIMIT;
      if (e < -EXC_LIMIT) e = -EXC_LIMIT;
      filt_q = 24'(clamp24(f + ((alpha * (e - f)) >>> 16)));
      fresh = e;
      burst_phase = burst_phase + set_step;
      burst_left = burst_left - 1'b1;
      n_burst++;
    end else begin
      y = clamp24(f + ((alpha * (raw - f)) >>> 16));
      filt_q = y[23:0];
      fresh = clamp24((y * gain) >>> 16);
      n_feedback++;
    end
    line_mem[wr_ptr] = fresh[23:0];
    wr_ptr = wr_ptr + 1'b1;
    res = fresh / 256;
    if (res > 64'sd32767) res = 64'sd32767;
    if (res < -64'sd32768) res = -64'sd32768;
    return res[15:0];
  endfunction

  // one sample tick; valid stays up between ticks but for random input gaps
  task automatic send_tick(input logic strike, input logic [14:0] level, input logic known,
                           input logic signed [15:0] audio);
    int gap;
    logic signed [15:0] model_audio;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_strike <= strike;
    in_strike_level <= level;
    do @(posedge clk); while (!in_ready);
    model_audio = next_string_sample(strike, level);
    expected_audio.push_back(known ? audio : model_audio);
    n_ticks++;
    if (strike) n_strikes++;
  endtask

  // register write once the voice is idle and every sample has come out
  task automatic write_reg(input reg_index_e sel, input logic [18:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (!(in_ready && expected_audio.size() == 0));
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    case (sel)
      REG_DELAY: set_delay = value;
      REG_ALPHA: set_alpha = value[16:0];
      REG_GAIN:  set_gain = value[15:0];
      REG_BODY:  set_body = value[16:0];
      REG_STEP:  set_step = value[15:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    n_regs++;
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each output transfer with the oldest predicted sample
  always @(posedge clk) begin : audio_check
    logic signed [15:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_audio.size() == 0) begin
        report_mismatch("sample with nothing pending", out_audio_out, 0);
      end else begin
        want = expected_audio.pop_front();
        if (out_audio_out !== want) report_mismatch("audio_out", out_audio_out, want);
      end
      n_checked++;
    end
  end

  initial begin : stimulus
    plan_row_t plan [0:PLAN_ROWS-1];
    int i;
    int ph;
    int k;
    int w;
    logic strike;
    logic [14:0] level;
    for (i = 0; i < 2048; i++) line_mem[i] = '0;
    wr_ptr = '0;
    filt_q = '0;
    lcg_q = 32'd1;
    burst_left = '0;
    burst_phase = '0;
    burst_amp = '0;
    set_delay = 19'd25600;
    set_alpha = 17'd32768;
    set_gain = 16'd65000;
    set_body = 17'd0;
    set_step = 16'd655;

    // silent line, zero-level strike, restrike, register clamping at both ends
    plan[0]  = '{ROW_TICK, REG_DELAY, 19'd0,      1'b0, 1'b1, 16'sd0};
    plan[1]  = '{ROW_TICK, REG_DELAY, 19'd32767,  1'b0, 1'b1, 16'sd0};
    plan[2]  = '{ROW_TICK, REG_DELAY, 19'd0,      1'b1, 1'b1, 16'sd0};
    plan[3]  = '{ROW_TICK, REG_DELAY, 19'd32767,  1'b1, 1'b0, 16'sd0};
    plan[4]  = '{ROW_TICK, REG_DELAY, 19'd12345,  1'b0, 1'b0, 16'sd0};
    plan[5]  = '{ROW_REG,  REG_DELAY, 19'd0,      1'b0, 1'b0, 16'sd0};
    plan[6]  = '{ROW_REG,  REG_ALPHA, 19'd131071, 1'b0, 1'b0, 16'sd0};
    plan[7]  = '{ROW_REG,  REG_GAIN,  19'd65535,  1'b0, 1'b0, 16'sd0};
    plan[8]  = '{ROW_REG,  REG_BODY,  19'd131071, 1'b0, 1'b0, 16'sd0};
    plan[9]  = '{ROW_REG,  REG_STEP,  19'd65535,  1'b0, 1'b0, 16'sd0};
    plan[10] = '{ROW_TICK, REG_DELAY, 19'd32767,  1'b1, 1'b0, 16'sd0};
    plan[11] = '{ROW_TICK, REG_DELAY, 19'd0,      1'b0, 1'b0, 16'sd0};
    plan[12] = '{ROW_TICK, REG_DELAY, 19'd0,      1'b0, 1'b0, 16'sd0};
    plan[13] = '{ROW_TICK, REG_DELAY, 19'd0,      1'b0, 1'b0, 16'sd0};
    plan[14] = '{ROW_TICK, REG_DELAY, 19'd1,      1'b1, 1'b0, 16'sd0};
    plan[15] = '{ROW_REG,  REG_DELAY, 19'd524287, 1'b0, 1'b0, 16'sd0};
    plan[16] = '{ROW_REG,  REG_ALPHA, 19'd0,      1'b0, 1'b0, 16'sd0};
    plan[17] = '{ROW_REG,  REG_GAIN,  19'd0,      1'b0, 1'b0, 16'sd0};
    plan[18] = '{ROW_REG,  REG_BODY,  19'd0,      1'b0, 1'b0, 16'sd0};
    plan[19] = '{ROW_REG,  REG_STEP,  19'd0,      1'b0, 1'b0, 16'sd0};
    plan[20] = '{ROW_TICK, REG_DELAY, 19'd16384,  1'b1, 1'b0, 16'sd0};
    plan[21] = '{ROW_TICK, REG_DELAY, 19'd21845,  1'b0, 1'b0, 16'sd0};
    plan[22] = '{ROW_TICK, REG_DELAY, 19'd32767,  1'b1, 1'b0, 16'sd0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].sel, plan[i].value);
      else send_tick(plan[i].strike, plan[i].value[14:0], plan[i].known, plan[i].audio);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph != PHASES - 1);
      case (ph)
        0: begin
          write_reg(REG_DELAY, 19'd512);
          write_reg(REG_ALPHA, 19'd3277);
          write_reg(REG_GAIN, 19'd65535);
          write_reg(REG_BODY, 19'd65536);
          write_reg(REG_STEP, 19'd32768);
        end
        3: begin
          write_reg(REG_DELAY, 19'd523776);
          write_reg(REG_ALPHA, 19'd65536);
          write_reg(REG_GAIN, 19'd0);
          write_reg(REG_BODY, 19'd0);
          write_reg(REG_STEP, 19'($urandom_range(0, 32768)));
        end
        default: begin
          write_reg(REG_DELAY, 19'($urandom_range(512, 48 << 8)));
          write_reg(REG_ALPHA, 19'($urandom_range(3277, 65536)));
          write_reg(REG_GAIN, 19'($urandom_range(52000, 65535)));
          write_reg(REG_BODY, 19'($urandom_range(0, 65536)));
          write_reg(REG_STEP, 19'($urandom_range(0, 32768)));
        end
      endcase
      if (ph == 2) hold_off_req = 1'b1;
      for (k = 0; k < PHASE_TICKS; k++) begin
        strike = (k == 0) || ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 7))
          0: level = 15'h7fff;
          1: level = 15'h0001;
          default: level = 15'($urandom_range(0, 32767));
        endcase
        send_tick(strike, level, 1'b0, 16'sd0);
      end
    end

    in_valid <= 1'b0;
    for (w = 0; w < 20000 && expected_audio.size() != 0; w++) @(posedge clk);
    repeat (64) @(posedge clk);
    if (expected_audio.size() != 0)
      report_mismatch("samples never delivered", expected_audio.size(), 0);

    $display("ran %0d ticks with %0d strikes and %0d register writes",
             n_ticks, n_strikes, n_regs);
    $display("model saw %0d burst and %0d feedback samples, %0d outputs checked",
             n_burst, n_feedback, n_checked);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("timeout with %0d samples still pending", expected_audio.size());
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
